@@ rtl/core/vendor_ie_tag_filter_defines.svh @@
// ----------------------------------------------------------------------------
// Vendor IE tag filter assertion macros
// Shared property wrappers; the using scope provides clk_i and rst_ni.
// ----------------------------------------------------------------------------
`ifndef VENDOR_IE_TAG_FILTER_DEFINES_SVH
`define VENDOR_IE_TAG_FILTER_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define VITF_ASSERT_SAME(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error("vendor_ie_tag_filter: same-cycle check failed");

// Next-cycle implication, disabled while in reset
`define VITF_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error("vendor_ie_tag_filter: next-cycle check failed");

`endif

@@ rtl/core/vitf_pkg.sv @@
// ----------------------------------------------------------------------------
// Vendor IE tag filter package
// Register indexes, reset values, parser phases and result types.
// ----------------------------------------------------------------------------
`default_nettype none

package vitf_pkg;

  // Register reset values
  localparam logic [7:0] ELEMENT_TYPE_RST = 8'hdd;
  localparam logic [7:0] TAG_FIRST_RST    = 8'h56;
  localparam logic [7:0] TAG_SECOND_RST   = 8'haf;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ELEMENT_TYPE = 2'd0,
    CFG_TAG_FIRST    = 2'd1,
    CFG_TAG_SECOND   = 2'd2
  } cfg_idx_e;

  // Parser phases; the unused code behaves like PH_TYPE
  typedef enum logic [1:0] {
    PH_TYPE    = 2'd0,
    PH_LEN     = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_e;

  // Result queue sizing
  localparam int unsigned MAX_RES = 3;
  localparam int unsigned RES_CNT_W = $clog2(MAX_RES + 1);
  localparam int unsigned QDEPTH = 8;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       element_last;
    logic       truncated;
  } result_t;

  // Results produced by one parsed byte, oldest in slot 0
  typedef struct packed {
    logic [RES_CNT_W-1:0]      count;
    result_t [MAX_RES-1:0]     res;
  } push_t;

endpackage

`default_nettype wire

@@ rtl/core/vitf_if.sv @@
// ----------------------------------------------------------------------------
// Vendor IE tag filter channels
// Valid/ready byte input channel and filtered result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface vitf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       buffer_end;

  modport source (output valid, output data_byte, output buffer_end, input ready);
  modport sink   (input valid, input data_byte, input buffer_end, output ready);
endinterface

interface vitf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] payload_byte;
  logic       element_last;
  logic       truncated;

  modport source (output valid, output payload_byte, output element_last,
                  output truncated, input ready);
  modport sink   (input valid, input payload_byte, input element_last,
                  input truncated, output ready);
endinterface

`default_nettype wire

@@ rtl/core/vitf_parse.sv @@
// ----------------------------------------------------------------------------
// Vendor IE tag filter parser
// Input register, configuration registers and the TLV walk for one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module vitf_parse (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [vitf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [vitf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  vitf_in_if.sink                             in_ch,
  input  wire logic                           space_ok_i,
  output vitf_pkg::push_t                     push_o
);
  import vitf_pkg::*;

  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       end_q;
  logic       fire;

  logic [7:0] element_type_q, tag_first_q, tag_second_q;

  phase_e     phase_q, phase_d;
  logic       tm_q, tm_d;
  logic [7:0] bl_q, bl_d;
  logic [1:0] idx_q, idx_d;
  logic       emit_q, emit_d;
  logic [7:0] held0_q, held0_d, held1_q, held1_d;

  logic [7:0] bl_dec;
  logic       done;
  logic       trunc;

  // Process the held byte only when the queue can take a full match
  assign fire        = in_valid_q & space_ok_i;
  assign in_ch.ready = ~in_valid_q | fire;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      byte_q <= in_ch.data_byte;
      end_q  <= in_ch.buffer_end;
    end
  end

  // Configuration registers; unknown indexes are ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      element_type_q <= ELEMENT_TYPE_RST;
      tag_first_q    <= TAG_FIRST_RST;
      tag_second_q   <= TAG_SECOND_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ELEMENT_TYPE: element_type_q <= cfg_data_i[7:0];
        CFG_TAG_FIRST:    tag_first_q    <= cfg_data_i[7:0];
        CFG_TAG_SECOND:   tag_second_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Walk one byte of the element list
  assign bl_dec = bl_q - 8'd1;
  assign done   = (bl_dec == 8'd0);
  assign trunc  = end_q & ~done;

  always_comb begin
    phase_d = phase_q;
    tm_d    = tm_q;
    bl_d    = bl_q;
    idx_d   = idx_q;
    emit_d  = emit_q;
    held0_d = held0_q;
    held1_d = held1_q;
    push_o  = '0;

    if (fire) begin
      case (phase_q)
        PH_LEN: begin
          bl_d    = byte_q;
          idx_d   = 2'd0;
          emit_d  = 1'b0;
          phase_d = (byte_q == 8'd0) ? PH_TYPE : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          bl_d = bl_dec;
          if (emit_q) begin
            push_o.count                  = RES_CNT_W'(1);
            push_o.res[0].payload_byte    = byte_q;
            push_o.res[0].element_last    = done | end_q;
            push_o.res[0].truncated       = trunc;
          end else if (idx_q == 2'd0) begin
            held0_d = byte_q;
            idx_d   = 2'd1;
          end else if (idx_q == 2'd1) begin
            held1_d = byte_q;
            idx_d   = 2'd2;
          end else if (idx_q == 2'd2) begin
            idx_d = 2'd3;
            // Decide the match on the third payload byte
            if (tm_q && (held1_q == tag_first_q) && (byte_q == tag_second_q)) begin
              emit_d                     = 1'b1;
              push_o.count               = RES_CNT_W'(3);
              push_o.res[0].payload_byte = held0_q;
              push_o.res[1].payload_byte = held1_q;
              push_o.res[2].payload_byte = byte_q;
              push_o.res[2].element_last = done | end_q;
              push_o.res[2].truncated    = trunc;
            end
          end
          if (done) begin
            phase_d = PH_TYPE;
          end
        end
        default: begin
          tm_d    = (byte_q == element_type_q);
          phase_d = PH_LEN;
        end
      endcase

      // Drop all parsing state at the end of a buffer
      if (end_q) begin
        phase_d = PH_TYPE;
        tm_d    = 1'b0;
        bl_d    = 8'd0;
        idx_d   = 2'd0;
        emit_d  = 1'b0;
      end
    end
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TYPE;
      tm_q    <= 1'b0;
      bl_q    <= 8'd0;
      idx_q   <= 2'd0;
      emit_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      tm_q    <= tm_d;
      bl_q    <= bl_d;
      idx_q   <= idx_d;
      emit_q  <= emit_d;
    end
  end

  // Held payload bytes
  always_ff @(posedge clk_i) begin
    held0_q <= held0_d;
    held1_q <= held1_d;
  end

endmodule

`default_nettype wire

@@ rtl/core/vitf_outq.sv @@
// ----------------------------------------------------------------------------
// Vendor IE tag filter result queue
// Takes up to three results per cycle, hands out one per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module vitf_outq (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire vitf_pkg::push_t push_i,
  output logic                 space_ok_o,
  vitf_out_if.source           out_ch
);
  import vitf_pkg::*;

  result_t             mem_q [QDEPTH];
  logic [QPTR_W-1:0]   head_q, tail_q;
  logic [QCNT_W-1:0]   cnt_q;
  logic                pop;
  result_t             head_res;

  assign pop        = out_ch.valid & out_ch.ready;
  assign space_ok_o = (cnt_q <= QCNT_W'(QDEPTH - MAX_RES));

  // Store the new results in order behind the tail
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MAX_RES; k++) begin
      if (k < int'(push_i.count)) begin
        mem_q[tail_q + QPTR_W'(k)] <= push_i.res[k];
      end
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      tail_q <= tail_q + QPTR_W'(push_i.count);
      head_q <= head_q + QPTR_W'(pop);
      cnt_q  <= cnt_q + QCNT_W'(push_i.count) - QCNT_W'(pop);
    end
  end

  // Present the oldest result
  assign head_res            = mem_q[head_q];
  assign out_ch.valid        = (cnt_q != '0);
  assign out_ch.payload_byte = head_res.payload_byte;
  assign out_ch.element_last = head_res.element_last;
  assign out_ch.truncated    = head_res.truncated;

endmodule

`default_nettype wire

@@ rtl/core/vendor_ie_tag_filter.sv @@
// Vendor IE tag filter
//   in_ch  : one raw byte of a type-length-value element list per transfer,
//            buffer_end marks the last byte of a buffer.
//   out_ch : one payload byte of each matching element per transfer, with
//            element_last on the final byte emitted for the element and
//            truncated when the buffer cut that element short.
//   cfg    : cfg_we_i/cfg_idx_i/cfg_data_i write element_type (0),
//            tag_first (1) and tag_second (2); write only while idle.
// Throughput is one input byte per cycle while three queue entries are free.
// The byte sits in an input register and is parsed into an 8-entry result
// queue. A match queues three results at once; the queue drains one per
// cycle while the receiver is ready. The input register holds its byte while
// fewer than three queue entries are free, so a stalled receiver stops the
// input side after the queue fills.
// Reset restores the register defaults, returns the parser to expecting a
// type byte and empties the queue.
// ----------------------------------------------------------------------------
// Vendor IE tag filter top level
// Filters vendor information elements by type and two identifier bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module vendor_ie_tag_filter (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [vitf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [vitf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  vitf_in_if.sink                              in_ch,
  vitf_out_if.source                           out_ch
);
  import vitf_pkg::*;

  push_t push;
  logic  space_ok;

  // Parse stage
  vitf_parse u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch),
    .space_ok_i (space_ok),
    .push_o     (push)
  );

  // Result queue
  vitf_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .space_ok_o (space_ok),
    .out_ch     (out_ch)
  );

endmodule

`default_nettype wire

@@ rtl/core/vitf_port_check.sv @@
// ----------------------------------------------------------------------------
// Vendor IE tag filter port checker
// Port-level properties of the filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "vendor_ie_tag_filter_defines.svh"

module vitf_port_check (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_payload_byte_i,
  input wire logic       out_element_last_i,
  input wire logic       out_truncated_i
);

  // Hold a stalled result
  `VITF_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_payload_byte_i) && $stable(out_element_last_i) && $stable(out_truncated_i))

  // A truncated byte always closes its element
  `VITF_ASSERT_SAME(a_trunc_last, out_valid_i && out_truncated_i, out_element_last_i)

  // An empty queue only fills from an input transfer that passed the input register
  `VITF_ASSERT_SAME(a_out_cause, $rose(out_valid_i), $past(in_valid_i && in_ready_i, 2))

endmodule

bind vendor_ie_tag_filter vitf_port_check u_port_check (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_ch.valid),
  .in_ready_i         (in_ch.ready),
  .out_valid_i        (out_ch.valid),
  .out_ready_i        (out_ch.ready),
  .out_payload_byte_i (out_ch.payload_byte),
  .out_element_last_i (out_ch.element_last),
  .out_truncated_i    (out_ch.truncated)
);

`default_nettype wire

@@ tb/sv/vendor_ie_tag_filter_tb.sv @@
// ----------------------------------------------------------------------------
// Vendor IE tag filter testbench
// Feeds element byte streams with random gaps and stalls on both channels,
// predicts the filtered payload bytes and checks every result transfer.
// ----------------------------------------------------------------------------
module vendor_ie_tag_filter_tb;
  import vitf_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned QUIET_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } ie_byte_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  vitf_in_if  in_ch();
  vitf_out_if out_ch();

  vendor_ie_tag_filter u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  always #2 clk_i = ~clk_i;

  // Register copies
  logic [7:0] element_type_r = ELEMENT_TYPE_RST;
  logic [7:0] tag_first_r    = TAG_FIRST_RST;
  logic [7:0] tag_second_r   = TAG_SECOND_RST;

  // Parser copy
  phase_e     ie_phase    = PH_TYPE;
  logic       type_hit    = 1'b0;
  logic [7:0] bytes_left  = '0;
  logic [1:0] payload_idx = '0;
  logic [7:0] held [2];
  logic       emitting    = 1'b0;

  ie_byte_t pend_q [$];
  result_t  payload_due_q [$];
  int       queued_bytes = 0;

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  bit          tx_busy = 1'b0;
  ie_byte_t    tx_cur;

  bit          hold_req = 1'b0;
  bit          hold_ack = 1'b0;
  int unsigned rx_hold_left = 0;

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  function automatic void push_payload(logic [7:0] b, logic last, logic trunc);
    result_t r;
    r = '{payload_byte: b, element_last: last, truncated: trunc};
    payload_due_q.insert(payload_due_q.size(), r);
  endfunction

  // Advance the parser copy by one accepted byte and queue what it emits
  function automatic void parse_ie_byte(logic [7:0] b, logic buf_end);
    logic done;
    logic trunc;
    case (ie_phase)
      PH_LEN: begin
        bytes_left  = b;
        payload_idx = '0;
        emitting    = 1'b0;
        ie_phase    = (b == 8'd0) ? PH_TYPE : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        bytes_left = bytes_left - 8'd1;
        done  = (bytes_left == 8'd0);
        trunc = buf_end && !done;
        if (emitting) begin
          push_payload(b, done || buf_end, trunc);
        end else if (payload_idx < 2'd2) begin
          held[payload_idx[0]] = b;
          payload_idx = payload_idx + 2'd1;
        end else if (payload_idx == 2'd2) begin
          payload_idx = 2'd3;
          if (type_hit && held[1] == tag_first_r && b == tag_second_r) begin
            emitting = 1'b1;
            push_payload(held[0], 1'b0, 1'b0);
            push_payload(held[1], 1'b0, 1'b0);
            push_payload(b, done || buf_end, trunc);
          end
        end
        if (done) ie_phase = PH_TYPE;
      end
      default: begin
        type_hit = (b == element_type_r);
        ie_phase = PH_LEN;
      end
    endcase
    // Drop all parsing state at the end of a buffer
    if (buf_end) begin
      ie_phase    = PH_TYPE;
      type_hit    = 1'b0;
      bytes_left  = '0;
      payload_idx = '0;
      emitting    = 1'b0;
    end
  endfunction

  // Input driver: hold each byte until its transfer, predict on transfer
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      tx_busy = 1'b0;
      in_ch.valid <= 1'b0;
    end else begin
      if (tx_busy && in_ch.ready) begin
        parse_ie_byte(tx_cur.data_byte, tx_cur.buffer_end);
        tx_busy = 1'b0;
      end
      if (!tx_busy && pend_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        tx_cur  = pend_q.pop_front();
        tx_busy = 1'b1;
      end
      in_ch.valid <= tx_busy;
      if (tx_busy) begin
        in_ch.data_byte  <= tx_cur.data_byte;
        in_ch.buffer_end <= tx_cur.buffer_end;
      end else begin
        in_ch.data_byte  <= 8'($urandom);
        in_ch.buffer_end <= 1'($urandom_range(1));
      end
    end
  end

  // Receiver hold-off counter
  always @(posedge clk_i) begin
    if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
    end else if (hold_req != hold_ack) begin
      rx_hold_left <= HOLD_CYCLES;
      hold_ack     <= hold_req;
    end
  end

  // Result monitor: compare each transfer with the oldest expected byte
  always @(posedge clk_i) begin : result_mon
    result_t want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (payload_due_q.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("unexpected payload byte %02h last %0b trunc %0b",
                     out_ch.payload_byte, out_ch.element_last, out_ch.truncated);
        end else begin
          want = payload_due_q.pop_front();
          if (out_ch.payload_byte !== want.payload_byte ||
              out_ch.element_last !== want.element_last ||
              out_ch.truncated !== want.truncated) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display("payload mismatch: expected %02h/%0b/%0b got %02h/%0b/%0b",
                       want.payload_byte, want.element_last, want.truncated,
                       out_ch.payload_byte, out_ch.element_last, out_ch.truncated);
          end
        end
      end
      out_ch.ready <= (rx_hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic queue_byte(input logic [7:0] b, input logic buf_end);
    ie_byte_t e;
    e = '{data_byte: b, buffer_end: buf_end};
    pend_q.insert(pend_q.size(), e);
    queued_bytes++;
  endtask

  // Queue the first n_send bytes of an element; tags follow the registers on a hit
  task automatic queue_element(input logic [7:0] etype, input int len, input int n_send,
                               input bit hit, input bit mark_end);
    logic [7:0] b;
    for (int i = 0; i < n_send; i++) begin
      case (i)
        0:       b = etype;
        1:       b = len[7:0];
        3:       b = hit ? tag_first_r : 8'($urandom);
        4:       b = hit ? tag_second_r : 8'($urandom);
        default: b = 8'($urandom);
      endcase
      queue_byte(b, mark_end && (i == n_send - 1));
    end
  endtask

  // Mostly well-formed matching elements, some misses, cuts and noise
  task automatic queue_random_elements(input int n_bytes);
    int start;
    int kind;
    int len;
    int n_send;
    bit hit;
    bit mark_end;
    logic [7:0] etype;
    start = queued_bytes;
    while (queued_bytes - start < n_bytes) begin
      kind  = $urandom_range(99);
      len   = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 3);
      etype = element_type_r;
      hit   = 1'b1;
      if (kind < 10) begin
        queue_byte(8'($urandom), $urandom_range(9) < 7);
      end else begin
        if (kind < 20) begin
          etype = 8'($urandom);
          hit   = 1'($urandom_range(1));
        end else if (kind < 30) begin
          hit = 1'b0;
        end else if (kind < 36) begin
          len = $urandom_range(2);
        end
        if ($urandom_range(99) < 15) begin
          n_send   = $urandom_range(len + 1, 1);
          mark_end = 1'b1;
        end else begin
          n_send   = len + 2;
          mark_end = ($urandom_range(9) == 0);
        end
        queue_element(etype, len, n_send, hit, mark_end);
      end
    end
  endtask

  // Pause the sender until all results are in and the block has gone quiet
  task automatic wait_drained();
    while (pend_q.size() != 0 || tx_busy || payload_due_q.size() != 0)
      @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_ELEMENT_TYPE: element_type_r = val;
      CFG_TAG_FIRST:    tag_first_r    = val;
      CFG_TAG_SECOND:   tag_second_r   = val;
      default: ;  // spare index: write has no effect
    endcase
  endtask

  task automatic program_regs(input logic [7:0] etype, input logic [7:0] tag1,
                              input logic [7:0] tag2, input bit hit_spare);
    write_reg(CFG_ELEMENT_TYPE, etype);
    write_reg(CFG_TAG_FIRST, tag1);
    write_reg(CFG_TAG_SECOND, tag2);
    if (hit_spare) write_reg(CFG_IDX_SPARE, 8'($urandom));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Stimulus sequence
  initial begin
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = '0;
    in_ch.buffer_end = 1'b0;
    out_ch.ready     = 1'b0;
    rst_ni           = 1'b0;
    tx_idle_pct      = 35;
    rx_idle_pct      = 81;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // matching element with exactly three payload bytes
    queue_byte(element_type_r, 1'b0); queue_byte(8'd3, 1'b0); queue_byte(8'h00, 1'b0);
    queue_byte(tag_first_r, 1'b0);    queue_byte(tag_second_r, 1'b0);
    // empty element of another type
    queue_byte(8'h7f, 1'b0); queue_byte(8'h00, 1'b0);
    // short payload: type and first tag match but no deciding byte
    queue_byte(element_type_r, 1'b0); queue_byte(8'd2, 1'b0);
    queue_byte(8'hff, 1'b0);          queue_byte(tag_first_r, 1'b0);
    // buffer ends on the deciding byte of a long matching element
    queue_byte(element_type_r, 1'b0); queue_byte(8'hff, 1'b0); queue_byte(8'h00, 1'b0);
    queue_byte(tag_first_r, 1'b0);    queue_byte(tag_second_r, 1'b1);
    // buffer ends inside an element not yet matched
    queue_byte(element_type_r, 1'b0); queue_byte(8'd6, 1'b0);
    queue_byte(8'h11, 1'b0);          queue_byte(8'h22, 1'b1);
    // buffer ends on a type byte, then on a length byte
    queue_byte(8'h3c, 1'b1);
    queue_byte(element_type_r, 1'b0); queue_byte(8'd9, 1'b1);
    // matched element that completes on the last byte of the buffer
    queue_byte(element_type_r, 1'b0); queue_byte(8'd4, 1'b0); queue_byte(8'hff, 1'b0);
    queue_byte(tag_first_r, 1'b0);    queue_byte(tag_second_r, 1'b0);
    queue_byte(8'h00, 1'b1);

    queue_random_elements(100);
    wait_drained();

    program_regs(8'h00, 8'h00, 8'hff, 1'b1);
    queue_random_elements(110);
    wait_drained();

    tx_idle_pct = 81;
    rx_idle_pct = 35;
    program_regs(8'hff, 8'hff, 8'h00, 1'b0);
    queue_random_elements(100);
    wait_drained();

    // no idling; stall the receiver while the sender keeps offering
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    program_regs(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
    queue_random_elements(80);
    hold_req <= ~hold_req;
    queue_random_elements(20);
    wait_drained();

    if (error_count == 0 && payload_due_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/vitf_pkg.sv
rtl/core/vitf_if.sv
rtl/core/vitf_parse.sv
rtl/core/vitf_outq.sv
rtl/core/vendor_ie_tag_filter.sv
rtl/core/vitf_port_check.sv
tb/sv/vendor_ie_tag_filter_tb.sv
